// File: rtl/stc_pkg.sv
// Shared types, constants and rounding helpers for spherical_to_tool_pose.
// Holds the CORDIC angle table and the data carried along the cell row.
// No dependencies.
package stc_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STEPS    = 30;
   localparam int RADIUS_W        = 20;
   localparam int POLAR_W         = 18;
   localparam int AZIMUTH_W       = 19;
   localparam int PIVOT_W         = 24;
   localparam int POS_W           = 25;
   localparam int AXIS_W          = 18;
   localparam int WORK_W          = 33;
   localparam int PROD_W          = 2 * WORK_W;

   localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;
   localparam logic signed [WORK_W-1:0] PI_Q30      = 33'sd3373259426;
   localparam logic signed [WORK_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [WORK_W-1:0] GAIN_Q30    = 33'sd652032874;
   localparam logic signed [AXIS_W-1:0] UNIT_Q16    = 18'sd65536;
   localparam logic signed [POS_W+1:0]  POS_HI      = 27'sd9437182;
   localparam logic signed [POS_W+1:0]  POS_LO      = -27'sd9437183;

   localparam logic [1:0] REG_PIVOT_X = 2'd0;
   localparam logic [1:0] REG_PIVOT_Y = 2'd1;
   localparam logic [1:0] REG_PIVOT_Z = 2'd2;

   typedef struct packed {
      logic signed [WORK_W-1:0] x;
      logic signed [WORK_W-1:0] y;
      logic signed [WORK_W-1:0] z;
      logic                     flip;
   } lane_type;

   typedef struct packed {
      logic                valid;
      logic [RADIUS_W-1:0] radius;
      lane_type            pol;
      lane_type            az;
   } cell_type;

   function automatic logic signed [WORK_W-1:0] atan_q30(input int idx);
      logic signed [WORK_W-1:0] v;
      case (idx)
         0:  v = 33'sd843314857;
         1:  v = 33'sd497837829;
         2:  v = 33'sd263043837;
         3:  v = 33'sd133525159;
         4:  v = 33'sd67021687;
         5:  v = 33'sd33543516;
         6:  v = 33'sd16775851;
         7:  v = 33'sd8388437;
         8:  v = 33'sd4194283;
         9:  v = 33'sd2097149;
         default: v = 33'sd1 <<< (30 - idx);
      endcase
      return v;
   endfunction

   function automatic logic signed [AXIS_W-1:0] sat_q16(input logic signed [WORK_W+1:0] v);
      logic signed [AXIS_W-1:0] r;
      if (v > 35'sd65536)
         r = UNIT_Q16;
      else if (v < -35'sd65536)
         r = -UNIT_Q16;
      else
         r = v[AXIS_W-1:0];
      return r;
   endfunction

   function automatic logic signed [AXIS_W-1:0] q30_to_q16(input logic signed [WORK_W-1:0] v);
      logic signed [WORK_W+1:0] t;
      t = ($signed({{2{v[WORK_W-1]}}, v}) + 35'sd8192) >>> 14;
      return sat_q16(t);
   endfunction

   function automatic logic signed [AXIS_W-1:0] q60_to_q16(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = (v + (66'sd1 <<< 43)) >>> 44;
      return sat_q16(t[WORK_W+1:0]);
   endfunction

endpackage

// File: rtl/stc_cordic_cell.sv
// One CORDIC rotation step for the polar and the azimuth lanes.
// Depends on stc_pkg for the cell data type and the angle table.
module stc_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  stc_pkg::cell_type in_item,
   output stc_pkg::cell_type out_item
);

   localparam logic signed [stc_pkg::WORK_W-1:0] ATAN = stc_pkg::atan_q30(IDX);

   stc_pkg::cell_type item_ff, item_in;

   function automatic stc_pkg::lane_type rotate(input stc_pkg::lane_type l);
      stc_pkg::lane_type o;
      logic signed [stc_pkg::WORK_W-1:0] dx, dy;
      dx = l.y >>> IDX;
      dy = l.x >>> IDX;
      o.flip = l.flip;
      if (!l.z[stc_pkg::WORK_W-1]) begin
         o.x = l.x - dx;
         o.y = l.y + dy;
         o.z = l.z - ATAN;
      end else begin
         o.x = l.x + dx;
         o.y = l.y - dy;
         o.z = l.z + ATAN;
      end
      return o;
   endfunction

   always_comb begin
      item_in        = in_item;
      item_in.valid  = in_item.valid && !reset;
      item_in.pol    = rotate(in_item.pol);
      item_in.az     = rotate(in_item.az);
   end

   always_ff @(posedge clock) begin
      if (enable || reset)
         item_ff <= item_in;
   end

   assign out_item = item_ff;

endmodule

// File: rtl/spherical_to_tool_pose.sv
// Top level: spherical coordinate about a pivot to tool position and axes.
// Depends on stc_pkg and stc_cordic_cell (a row of 30 rotation cells).
//
// channel | dir | ports                          | payload
// req     | in  | req_tvalid/tready/tdata[63:0]  | radius, polar_angle, azimuth
// rsp     | out | rsp_tvalid/tready/tdata[239:0] | position, right, down, forward
// csr     | in  | csr_valid/ready/index/data     | pivot_x, pivot_y, pivot_z
//
// One transfer per cycle while rsp is not stalled; stages are the input stage, 30 CORDIC
// cells, three product/rounding stages and the output register.
// Synchronous reset empties the pipeline and clears the pivot to zero.
// A stalled rsp holds the whole pipeline; req_tready drops with it.
module spherical_to_tool_pose #(
   parameter int ANGLE_FRAC_BITS = stc_pkg::ANGLE_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // radius[19:0], polar_angle[37:20], azimuth[56:38]
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z (25 each), right_x/y/z, down_x/y/z, fwd_x/y/z (18 each)
   output logic [239:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data
);

   localparam int W  = stc_pkg::WORK_W;
   localparam int PW = stc_pkg::PROD_W;
   localparam int N  = stc_pkg::CORDIC_STEPS;
   localparam int AW = stc_pkg::AXIS_W;
   localparam logic [63:0] PI_ANG_W =
      (stc_pkg::PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
   localparam logic signed [W-1:0] PI_ANG = $signed(PI_ANG_W[W-1:0]);

   logic enable;
   logic signed [23:0] pivot_x_ff, pivot_y_ff, pivot_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         pivot_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            stc_pkg::REG_PIVOT_X: pivot_x_ff <= csr_data;
            stc_pkg::REG_PIVOT_Y: pivot_y_ff <= csr_data;
            stc_pkg::REG_PIVOT_Z: pivot_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage: clamp, scale to Q30, fold into +-pi/2
   logic signed [W-1:0] pa_in, az_in, pa_z, az_z;
   stc_pkg::cell_type chain [0:N];
   stc_pkg::cell_type s0_in;

   function automatic stc_pkg::lane_type fold(input logic signed [W-1:0] z);
      stc_pkg::lane_type l;
      l.x = stc_pkg::GAIN_Q30;
      l.y = '0;
      l.flip = 1'b0;
      l.z = z;
      if (z > stc_pkg::HALF_PI_Q30) begin
         l.z = z - stc_pkg::PI_Q30;
         l.flip = 1'b1;
      end else if (z < -stc_pkg::HALF_PI_Q30) begin
         l.z = z + stc_pkg::PI_Q30;
         l.flip = 1'b1;
      end
      return l;
   endfunction

   always_comb begin
      pa_in = $signed({15'b0, req_tdata[37:20]});
      az_in = $signed({{14{req_tdata[56]}}, req_tdata[56:38]});
      if (pa_in > PI_ANG)
         pa_in = PI_ANG;
      if (az_in > PI_ANG)
         az_in = PI_ANG;
      else if (az_in < -PI_ANG)
         az_in = -PI_ANG;
      pa_z = pa_in <<< (30 - ANGLE_FRAC_BITS);
      az_z = az_in <<< (30 - ANGLE_FRAC_BITS);
      s0_in.valid  = req_tvalid && !reset;
      s0_in.radius = req_tdata[19:0];
      s0_in.pol    = fold(pa_z);
      s0_in.az     = fold(az_z);
   end

   stc_pkg::cell_type s0_ff;
   always_ff @(posedge clock) begin
      if (enable || reset)
         s0_ff <= s0_in;
   end
   assign chain[0] = s0_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      stc_cordic_cell #(.IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .in_item (chain[g]),
         .out_item(chain[g+1])
      );
   end

   // P1: unfold and products
   logic signed [W-1:0] sp_c, cp_c, sa_c, ca_c;
   assign sp_c = chain[N].pol.flip ? -chain[N].pol.y : chain[N].pol.y;
   assign cp_c = chain[N].pol.flip ? -chain[N].pol.x : chain[N].pol.x;
   assign sa_c = chain[N].az.flip  ? -chain[N].az.y  : chain[N].az.y;
   assign ca_c = chain[N].az.flip  ? -chain[N].az.x  : chain[N].az.x;

   logic p1_valid_ff;
   logic [19:0] p1_r_ff;
   logic signed [W-1:0] p1_sp_ff, p1_cp_ff, p1_sa_ff, p1_ca_ff;
   logic signed [PW-1:0] p1_sc_ff, p1_ss_ff, p1_cc_ff, p1_cs_ff;

   always_ff @(posedge clock) begin
      if (reset)
         p1_valid_ff <= 1'b0;
      else if (enable)
         p1_valid_ff <= chain[N].valid;
      if (enable) begin
         p1_r_ff     <= chain[N].radius;
         p1_sp_ff    <= sp_c;
         p1_cp_ff    <= cp_c;
         p1_sa_ff    <= sa_c;
         p1_ca_ff    <= ca_c;
         p1_sc_ff    <= sp_c * ca_c;
         p1_ss_ff    <= sp_c * sa_c;
         p1_cc_ff    <= cp_c * ca_c;
         p1_cs_ff    <= cp_c * sa_c;
      end
   end

   // P2: round offsets direction, axis entries
   typedef struct packed {
      logic signed [AW-1:0] right_x, right_y, down_x, down_y, down_z, fwd_x, fwd_y, fwd_z;
   } axes_type;

   logic signed [PW-1:0] fx_w, fy_w;
   assign fx_w = (p1_sc_ff + (66'sd1 <<< 29)) >>> 30;
   assign fy_w = (p1_ss_ff + (66'sd1 <<< 29)) >>> 30;

   logic p2_valid_ff;
   logic [19:0] p2_r_ff;
   logic signed [W-1:0] p2_fx_ff, p2_fy_ff, p2_cp_ff;
   axes_type p2_axes_ff, p2_axes_in;

   always_comb begin
      p2_axes_in.right_x = stc_pkg::q30_to_q16(p1_sa_ff);
      p2_axes_in.right_y = stc_pkg::q30_to_q16(-p1_ca_ff);
      p2_axes_in.down_x  = stc_pkg::q60_to_q16(p1_cc_ff);
      p2_axes_in.down_y  = stc_pkg::q60_to_q16(p1_cs_ff);
      p2_axes_in.down_z  = stc_pkg::q30_to_q16(-p1_sp_ff);
      p2_axes_in.fwd_x   = stc_pkg::q60_to_q16(p1_sc_ff);
      p2_axes_in.fwd_y   = stc_pkg::q60_to_q16(p1_ss_ff);
      p2_axes_in.fwd_z   = stc_pkg::q30_to_q16(p1_cp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset)
         p2_valid_ff <= 1'b0;
      else if (enable)
         p2_valid_ff <= p1_valid_ff;
      if (enable) begin
         p2_r_ff     <= p1_r_ff;
         p2_fx_ff    <= fx_w[W-1:0];
         p2_fy_ff    <= fy_w[W-1:0];
         p2_cp_ff    <= p1_cp_ff;
         p2_axes_ff  <= p2_axes_in;
      end
   end

   // P3: radius products
   localparam int RW = W + 21;
   logic signed [20:0] r_s;
   assign r_s = $signed({1'b0, p2_r_ff});

   logic p3_valid_ff;
   logic signed [RW-1:0] p3_ox_ff, p3_oy_ff, p3_oz_ff;
   axes_type p3_axes_ff;

   always_ff @(posedge clock) begin
      if (reset)
         p3_valid_ff <= 1'b0;
      else if (enable)
         p3_valid_ff <= p2_valid_ff;
      if (enable) begin
         p3_ox_ff    <= r_s * p2_fx_ff;
         p3_oy_ff    <= r_s * p2_fy_ff;
         p3_oz_ff    <= r_s * p2_cp_ff;
         p3_axes_ff  <= p2_axes_ff;
      end
   end

   // P4: add pivot, saturate, output register
   function automatic logic signed [stc_pkg::POS_W-1:0] place(
      input logic signed [RW-1:0] prod, input logic signed [23:0] pivot);
      logic signed [RW-1:0] o;
      logic signed [stc_pkg::POS_W+1:0] s;
      logic signed [stc_pkg::POS_W-1:0] r;
      o = (prod + (54'sd1 <<< 29)) >>> 30;
      s = o[stc_pkg::POS_W+1:0] + {{3{pivot[23]}}, pivot};
      if (s > stc_pkg::POS_HI)
         r = stc_pkg::POS_HI[stc_pkg::POS_W-1:0];
      else if (s < stc_pkg::POS_LO)
         r = stc_pkg::POS_LO[stc_pkg::POS_W-1:0];
      else
         r = s[stc_pkg::POS_W-1:0];
      return r;
   endfunction

   logic rsp_valid_ff;
   logic [239:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in = {3'b0,
                     p3_axes_ff.fwd_z, p3_axes_ff.fwd_y, p3_axes_ff.fwd_x,
                     p3_axes_ff.down_z, p3_axes_ff.down_y, p3_axes_ff.down_x,
                     18'sd0, p3_axes_ff.right_y, p3_axes_ff.right_x,
                     place(p3_oz_ff, pivot_z_ff),
                     place(p3_oy_ff, pivot_y_ff),
                     place(p3_ox_ff, pivot_x_ff)};
   end

   assign enable = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (enable)
         rsp_valid_ff <= p3_valid_ff;
      if (enable)
         rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = enable;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output slot");

   a_right_z_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[128:111] == 18'd0))
      else $error("right_z nonzero");

   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");

endmodule

// File: dv/spherical_to_tool_pose_tb.sv
// Testbench for spherical_to_tool_pose: random and directed spherical poses
// checked against an in-bench CORDIC predictor through a small scoreboard.
// Depends on stc_pkg and the spherical_to_tool_pose RTL.
module spherical_to_tool_pose_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int RSP_W = 240;

   class pose_scoreboard;
      longint atan_q30_tab[stc_pkg::CORDIC_STEPS];
      longint pi_q30, half_pi_q30, pi_angle;
      longint pivot[3];
      logic [RSP_W-1:0] pose_queue[$];
      int fails;

      function longint atan_pow2_q62(int i);
         longint sum;
         longint unsigned term;
         bit neg;
         sum = 0;
         neg = 0;
         for (int n = 1; i * n <= 62; n += 2) begin
            term = (64'd1 << (62 - i * n)) / n;
            sum = neg ? sum - longint'(term) : sum + longint'(term);
            neg = !neg;
         end
         return sum;
      endfunction

      function longint atan_third_q62();
         longint unsigned p, n;
         longint sum;
         bit neg;
         p = (64'd1 << 62) / 3;
         n = 1;
         sum = 0;
         neg = 0;
         while (p != 0) begin
            sum = neg ? sum - longint'(p / n) : sum + longint'(p / n);
            neg = !neg;
            p = p / 9;
            n += 2;
         end
         return sum;
      endfunction

      function new();
         longint quarter;
         quarter = atan_pow2_q62(1) + atan_third_q62();
         atan_q30_tab[0] = (quarter + (64'sd1 << 31)) >>> 32;
         for (int i = 1; i < stc_pkg::CORDIC_STEPS; i++)
            atan_q30_tab[i] = (atan_pow2_q62(i) + (64'sd1 << 31)) >>> 32;
         pi_q30 = (quarter + (64'sd1 << 29)) >>> 30;
         half_pi_q30 = (quarter + (64'sd1 << 30)) >>> 31;
         pi_angle = (quarter + (64'sd1 << (59 - stc_pkg::ANGLE_FRAC_BITS)))
            >>> (60 - stc_pkg::ANGLE_FRAC_BITS);
         foreach (pivot[k]) pivot[k] = 0;
         fails = 0;
      endfunction

      function void set_pivot(logic [1:0] idx, logic [23:0] val);
         if (idx == stc_pkg::REG_PIVOT_X || idx == stc_pkg::REG_PIVOT_Y ||
             idx == stc_pkg::REG_PIVOT_Z)
            pivot[idx] = longint'($signed(val));
      endfunction

      function void sincos(longint z, output longint s, output longint c);
         longint x, y, dx, dy;
         bit flip;
         x = stc_pkg::GAIN_Q30;
         y = 0;
         flip = 0;
         if (z > half_pi_q30) begin
            z -= pi_q30;
            flip = 1;
         end else if (z < -half_pi_q30) begin
            z += pi_q30;
            flip = 1;
         end
         for (int i = 0; i < stc_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q30_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_q30_tab[i];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint round_shift(longint v, int sh);
         return (v + (64'sd1 << (sh - 1))) >>> sh;
      endfunction

      function logic [17:0] axis16(longint v, int sh);
         return 18'(limit(round_shift(v, sh), -65536, 65536));
      endfunction

      function logic [24:0] position(longint p, longint off);
         return 25'(limit(p + off, -9437183, 9437182));
      endfunction

      function void note_input(logic [63:0] word);
         longint r, pa, az, sp, cp, sa, ca, fx, fy;
         r = word[19:0];
         pa = limit(longint'(word[37:20]), 0, pi_angle);
         az = limit(longint'($signed(word[56:38])), -pi_angle, pi_angle);
         sincos(pa <<< (30 - stc_pkg::ANGLE_FRAC_BITS), sp, cp);
         sincos(az <<< (30 - stc_pkg::ANGLE_FRAC_BITS), sa, ca);
         fx = round_shift(sp * ca, 30);
         fy = round_shift(sp * sa, 30);
         pose_queue.push_back({3'b0,
            axis16(cp, 14), axis16(sp * sa, 44), axis16(sp * ca, 44),
            axis16(-sp, 14), axis16(cp * sa, 44), axis16(cp * ca, 44),
            18'd0, axis16(-ca, 14), axis16(sa, 14),
            position(pivot[2], round_shift(r * cp, 30)),
            position(pivot[1], round_shift(r * fy, 30)),
            position(pivot[0], round_shift(r * fx, 30))});
      endfunction

      function void check_pose(logic [RSP_W-1:0] got);
         logic [RSP_W-1:0] exp_pose;
         int lsb, w;
         if (pose_queue.size() == 0) begin
            $display("%0t: unexpected pose transfer %h", $time, got);
            fails++;
            return;
         end
         exp_pose = pose_queue.pop_front();
         for (int f = 0; f < 12; f++) begin
            lsb = f < 3 ? 25 * f : 75 + 18 * (f - 3);
            w = f < 3 ? 25 : 18;
            if (((got ^ exp_pose) >> lsb) & ((240'd1 << w) - 1)) begin
               $display("%0t: field %0d expected %h actual %h", $time, f,
                  (exp_pose >> lsb) & ((240'd1 << w) - 1),
                  (got >> lsb) & ((240'd1 << w) - 1));
               fails++;
            end
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   pose_scoreboard sb = new();
   int req_idle_pct = 0, rsp_stall_pct = 0;
   bit hold_rsp = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   spherical_to_tool_pose DUT (.*);

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_input(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pose(rsp_tdata);
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && hold_left == 0) begin
            hold_left = 300;
            hold_rsp = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
         end
      end
   end

   task send_pose(logic [19:0] r, logic [17:0] pa, logic [18:0] az);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, az, pa, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task write_reg(logic [1:0] idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_pivot(idx, val);
      csr_valid <= 0;
   endtask

   task drain();
      req_tvalid <= 0;
      wait (sb.pose_queue.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task random_poses(int count);
      logic [17:0] pa;
      for (int i = 0; i < count; i++) begin
         pa = $urandom_range(9) == 0 ? 18'($urandom) : 18'($urandom_range(205887));
         send_pose($urandom_range(9) == 0 ? 20'($urandom_range(3) + 1) : 20'($urandom),
            pa, $urandom_range(9) == 0 ? 19'($urandom) : 19'($urandom_range(411774) - 205887));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_pose(20'd1, 18'd0, 19'd0);
      send_pose(20'hFFFFF, 18'd0, 19'd0);
      send_pose(20'hFFFFF, 18'd205887, 19'd0);
      send_pose(20'hFFFFF, 18'h3FFFF, 19'd205887);
      send_pose(20'h80000, 18'd102944, -19'sd205887);
      send_pose(20'h7FFFF, 18'd51472, 19'h3FFFF);
      send_pose(20'd12345, 18'd205888, 19'h40000);
      send_pose(20'hFFFFF, 18'd102944, 19'd102944);
      send_pose(20'd1, 18'd205887, 19'h3FFFF);
      send_pose(20'h55555, 18'h2AAAA, 19'h15555);
      send_pose(20'hAAAAA, 18'h15555, 19'h2AAAA);
      drain();
      write_reg(stc_pkg::REG_PIVOT_X, 24'h7FFFFF);
      write_reg(stc_pkg::REG_PIVOT_Y, 24'h800000);
      write_reg(stc_pkg::REG_PIVOT_Z, 24'h7FFFFF);
      write_reg(REG_UNUSED, 24'h123456);
      send_pose(20'hFFFFF, 18'd0, 19'd0);
      send_pose(20'hFFFFF, 18'd205887, 19'd0);
      send_pose(20'hFFFFF, 18'd102944, 19'd205887);
      send_pose(20'hFFFFF, 18'd102944, 19'd0);
      drain();
      write_reg(stc_pkg::REG_PIVOT_X, 24'h800000);
      write_reg(stc_pkg::REG_PIVOT_Y, 24'h7FFFFF);
      write_reg(stc_pkg::REG_PIVOT_Z, 24'h800000);
      send_pose(20'hFFFFF, 18'd0, 19'd0);
      send_pose(20'hFFFFF, 18'd205887, 19'd102944);
      send_pose(20'hFFFFF, 18'd102944, -19'sd102944);
      random_poses(200);
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = ph == 0 ? 68 : (ph == 2 ? 25 : 0);
         rsp_stall_pct = ph == 1 ? 68 : (ph == 2 ? 25 : 0);
         write_reg(stc_pkg::REG_PIVOT_X, 24'($urandom));
         write_reg(stc_pkg::REG_PIVOT_Y, 24'($urandom));
         write_reg(stc_pkg::REG_PIVOT_Z, ph == 2 ? 24'd0 : 24'($urandom));
         if (ph == 1) begin
            hold_rsp <= 1;
            random_poses(60);
         end
         random_poses(200);
         drain();
      end
      if (sb.fails == 0)
         $display("spherical_to_tool_pose_tb OK");
      else
         $display("spherical_to_tool_pose_tb NOT OK");
      $finish;
   end

   initial begin
      #10ms;
      $display("spherical_to_tool_pose_tb NOT OK");
      $finish;
   end
endmodule
